>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ps2m_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// Depends on nothing.
`default_nettype none
package ps2m_pkg;

	localparam logic [7:0] ACK_BYTE        = 8'hFA;
	localparam logic [7:0] HDR_CHECK_MASK  = 8'hC8;
	localparam logic [7:0] HDR_CHECK_VALUE = 8'h08;
	localparam int         X_SIGN_POS      = 4;
	localparam int         Y_SIGN_POS      = 5;

	localparam int POS_W = 10;

	localparam logic [POS_W-1:0] MAX_X_RESET = 10'd304;
	localparam logic [POS_W-1:0] MAX_Y_RESET = 10'd184;
	localparam logic [POS_W-1:0] POS_X_RESET = 10'd152;
	localparam logic [POS_W-1:0] POS_Y_RESET = 10'd78;

	// Configuration register indexes
	localparam logic REG_CURSOR_MAX_X = 1'b0;
	localparam logic REG_CURSOR_MAX_Y = 1'b1;

	typedef enum logic [1:0] {
		PH_ACK,
		PH_HDR,
		PH_X,
		PH_Y
	} phase_t;

	// One framed packet, handed from the framer to the cursor unit
	typedef struct packed {
		logic [2:0] buttons;
		logic       x_sign;
		logic       y_sign;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} pkt_t;

endpackage
`default_nettype wire

>>> src/ps2m_front.sv
// Byte framer: acknowledge wait, header check and packet assembly.
// Depends on ps2m_pkg.
`default_nettype none
module ps2m_front import ps2m_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] mouse_byte,
	output pkt_t            pkt,
	output logic            pkt_push
);

	phase_t     phase_q, phase_d;
	logic [7:0] header_q;
	logic [7:0] x_q;
	logic       hdr_load, x_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ACK;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_load) begin
			header_q <= mouse_byte;
		end
		if (x_load) begin
			x_q <= mouse_byte;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hdr_load = 1'b0;
		x_load   = 1'b0;
		pkt_push = 1'b0;
		if (take) begin
			unique case (phase_q)
				PH_ACK: begin
					if (mouse_byte == ACK_BYTE) phase_d = PH_HDR;
				end
				PH_HDR: begin
					// drop bytes that cannot start a packet
					if ((mouse_byte & HDR_CHECK_MASK) == HDR_CHECK_VALUE) begin
						hdr_load = 1'b1;
						phase_d  = PH_X;
					end
				end
				PH_X: begin
					x_load  = 1'b1;
					phase_d = PH_Y;
				end
				PH_Y: begin
					pkt_push = 1'b1;
					phase_d  = PH_HDR;
				end
				default: phase_d = PH_ACK;
			endcase
		end
	end

	assign pkt.buttons = header_q[2:0];
	assign pkt.x_sign  = header_q[X_SIGN_POS];
	assign pkt.y_sign  = header_q[Y_SIGN_POS];
	assign pkt.x_byte  = x_q;
	assign pkt.y_byte  = mouse_byte;

endmodule
`default_nettype wire

>>> src/ps2m_fifo.sv
// Small flip-flop queue between the framer and the cursor unit.
// Depends on nothing.
`default_nettype none
module ps2m_fifo #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (rd_en) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);

endmodule
`default_nettype wire

>>> src/ps2m_back.sv
// Cursor unit: delta extension, position update, clamp and result register.
// Also holds the two cursor limit registers. Depends on ps2m_pkg.
`default_nettype none
module ps2m_back import ps2m_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [POS_W-1:0] cfg_data,
	input  wire pkt_t             pkt,
	input  wire logic             pkt_avail,
	output logic                  pkt_take,
	input  wire logic             pop,
	output logic                  empty,
	output logic [2:0]            buttons,
	output logic signed [8:0]     delta_x,
	output logic signed [9:0]     delta_y,
	output logic [POS_W-1:0]      cursor_x,
	output logic [POS_W-1:0]      cursor_y
);

	logic [POS_W-1:0] max_x_q, max_y_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic             out_valid_q;
	logic [8:0]       dx;
	logic [9:0]       ext_y, dy;
	logic [11:0]      sum_x, sum_y;
	logic [POS_W-1:0] new_x, new_y;

	function automatic logic [POS_W-1:0] clamp(input logic [11:0] s,
			input logic [POS_W-1:0] lim);
		if (s[11]) return '0;
		if (s[10:0] > {1'b0, lim}) return lim;
		return s[POS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CURSOR_MAX_X: max_x_q <= cfg_data;
				REG_CURSOR_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pkt_take = pkt_avail && (!out_valid_q || pop);

	assign dx    = {pkt.x_sign, pkt.x_byte};
	assign ext_y = {pkt.y_sign, pkt.y_sign, pkt.y_byte};
	assign dy    = 10'(10'd0 - ext_y);
	assign sum_x = {2'b00, pos_x_q} + {{3{dx[8]}}, dx};
	assign sum_y = {2'b00, pos_y_q} + {{2{dy[9]}}, dy};
	assign new_x = clamp(sum_x, max_x_q);
	assign new_y = clamp(sum_y, max_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= POS_X_RESET;
			pos_y_q     <= POS_Y_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (pkt_take) begin
				pos_x_q     <= new_x;
				pos_y_q     <= new_y;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			buttons  <= pkt.buttons;
			delta_x  <= $signed(dx);
			delta_y  <= $signed(dy);
			cursor_x <= new_x;
			cursor_y <= new_y;
		end
	end

	assign empty = !out_valid_q;

endmodule
`default_nettype wire

>>> src/ps2_mouse_packet_decoder.sv
// PS/2 mouse three-byte packet decoder, top level.
// Throughput: one byte per cycle, sustained; full rises only if results back up.
// A packet's result reaches the result ports after its third byte is taken, passing
// through the packet queue and then the cursor unit's result register.
// Reset: waits for the acknowledge byte, cursor at (152, 78), limits 304 / 184,
// packet queue and result register empty. Depends on ps2m_pkg and submodules.
`default_nettype none
module ps2_mouse_packet_decoder import ps2m_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// input beats
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       mouse_byte,
	// configuration writes
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [POS_W-1:0] cfg_data,
	// result beats
	output logic                  empty,
	input  wire logic             pop,
	output logic [2:0]            buttons,
	output logic signed [8:0]     delta_x,
	output logic signed [9:0]     delta_y,
	output logic [POS_W-1:0]      cursor_x,
	output logic [POS_W-1:0]      cursor_y
);

	// The front end frames bytes into packets; the back end applies them to
	// the cursor. The packet queue between them lets each side stall alone.
	logic take;
	pkt_t front_pkt;
	logic front_push;
	logic [$bits(pkt_t)-1:0] q_rd_data;
	pkt_t back_pkt;
	logic q_full, q_empty;
	logic back_take;

	// Accept a beat whenever the packet queue has room. A stalled result
	// back end only blocks input once the queue fills up.
	assign full = q_full;
	assign take = push && !q_full;

	ps2m_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.mouse_byte (mouse_byte),
		.pkt        (front_pkt),
		.pkt_push   (front_push)
	);

	ps2m_fifo #(
		.WIDTH ($bits(pkt_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_pkt),
		.rd_en   (back_take),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign back_pkt = pkt_t'(q_rd_data);

	// Advance the cursor one packet per cycle while the result register is
	// free or being drained in the same cycle.
	ps2m_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (back_pkt),
		.pkt_avail (!q_empty),
		.pkt_take  (back_take),
		.pop       (pop),
		.empty     (empty),
		.buttons   (buttons),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.cursor_x  (cursor_x),
		.cursor_y  (cursor_y)
	);

endmodule
`default_nettype wire

>>> src/ps2m_checker.sv
// Port-level checker for the PS/2 mouse packet decoder, with its bind.
// Depends on ps2m_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ps2m_checker import ps2m_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic [7:0]       mouse_byte,
	input wire logic             cfg_we,
	input wire logic             cfg_index,
	input wire logic [POS_W-1:0] cfg_data,
	input wire logic             empty,
	input wire logic             pop,
	input wire logic [2:0]       buttons,
	input wire logic signed [8:0] delta_x,
	input wire logic signed [9:0] delta_y,
	input wire logic [POS_W-1:0] cursor_x,
	input wire logic [POS_W-1:0] cursor_y
);

	logic [POS_W-1:0] lim_x_q, lim_y_q;

	// Shadow the cursor limits from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q <= MAX_X_RESET;
			lim_y_q <= MAX_Y_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CURSOR_MAX_X) lim_x_q <= cfg_data;
			if (cfg_index == REG_CURSOR_MAX_Y) lim_y_q <= cfg_data;
		end
	end

	// the result register may only settle at the first edge seen in reset
	`ASSERT_NEXT(a_reset_empty, clk, 1'b0, !arst_n, empty,
		"result side not empty in reset")
	`ASSERT_NEXT(a_stall_hold, clk, !arst_n, !empty && !pop,
		!empty && $stable(cursor_x) && $stable(delta_x),
		"waiting result changed while stalled")
	`ASSERT_SAME(a_dy_range, clk, !arst_n, !empty, delta_y != -10'sd256,
		"vertical delta out of range")
	`ASSERT_SAME(a_x_clamp, clk, !arst_n, !empty, cursor_x <= lim_x_q,
		"cursor x above its limit")
	`ASSERT_SAME(a_y_clamp, clk, !arst_n, !empty, cursor_y <= lim_y_q,
		"cursor y above its limit")

	// inputs only watched for completeness of the port view
	logic unused_ok;
	assign unused_ok = ^{push, full, mouse_byte, buttons};

endmodule

bind ps2_mouse_packet_decoder ps2m_checker u_checker (.*);
`default_nettype wire

>>> sim/ps2_mouse_packet_decoder_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder: directed rows, then
// random packets under several cursor limits, checked against an in-bench decoder.
// Depends on ps2m_pkg and ps2_mouse_packet_decoder from src.
`timescale 1ns / 100ps
module ps2_mouse_packet_decoder_tb;
	import ps2m_pkg::*;

	// Hold-off after the last result before touching the limits: covers the block
	// latency plus margin for header or X bytes still in flight.
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 105;
	localparam int DIRECTED_ROWS = 26;

	// One decoded packet as it leaves the block
	typedef struct packed {
		logic [2:0]        buttons;
		logic signed [8:0] dx;
		logic signed [9:0] dy;
		logic [POS_W-1:0]  cx;
		logic [POS_W-1:0]  cy;
	} move_t;

	// Directed stimulus row; known marks a row whose result is typed in
	typedef struct packed {
		logic [7:0] mbyte;
		bit         known;
		move_t      want;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic [7:0]       mouse_byte = 8'h00;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_CURSOR_MAX_X;
	logic [POS_W-1:0] cfg_data = '0;
	logic             pop = 1'b0;
	wire              full;
	wire              empty;
	wire [2:0]        buttons;
	wire signed [8:0] delta_x;
	wire signed [9:0] delta_y;
	wire [POS_W-1:0]  cursor_x;
	wire [POS_W-1:0]  cursor_y;

	ps2_mouse_packet_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mouse_byte (mouse_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.empty      (empty),
		.pop        (pop),
		.buttons    (buttons),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y)
	);

	// Decoder mirror: framing phase, packet bytes, cursor and limits
	phase_t           frame_phase = PH_ACK;
	logic [7:0]       hdr_seen = '0;
	logic [7:0]       x_seen = '0;
	logic [POS_W-1:0] pos_x = POS_X_RESET;
	logic [POS_W-1:0] pos_y = POS_Y_RESET;
	logic [POS_W-1:0] lim_x = MAX_X_RESET;
	logic [POS_W-1:0] lim_y = MAX_Y_RESET;

	move_t pending_moves[$];
	int    mismatches = 0;
	int    cycle_count = 0;
	bit    steady = 1'b0;  // set for a stretch with no idling on either side

	// Rows walk every special case from reset, with limits 304 / 184 and the
	// cursor starting at (152, 78). Typed rows: full-scale moves in both
	// directions, a zero move, and mixed sign/button headers.
	localparam script_row_t SCRIPT[DIRECTED_ROWS] = '{
		'{8'h08, 1'b0, '0},  // valid-looking header before acknowledge: drop
		'{8'h00, 1'b0, '0},  // low extreme before acknowledge: drop
		'{8'hFF, 1'b0, '0},  // high extreme before acknowledge: drop
		'{8'hFA, 1'b0, '0},  // acknowledge: start framing
		'{8'hFA, 1'b0, '0},  // acknowledge again: bits 7 and 6 set, not a header
		'{8'h00, 1'b0, '0},  // bit 3 clear: skip
		'{8'h48, 1'b0, '0},  // bit 6 set: skip
		'{8'h88, 1'b0, '0},  // bit 7 set: skip
		'{8'h0F, 1'b0, '0},  // all buttons, both signs positive
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1, '{3'd7, 255, -255, 304, 0}},  // clamp at max x and at zero y
		'{8'h38, 1'b0, '0},  // both signs negative
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{3'd0, -256, 256, 48, 184}}, // most negative x, clamp at max y
		'{8'h08, 1'b0, '0},  // zero move
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{3'd0, 0, 0, 48, 184}},
		'{8'h19, 1'b0, '0},  // left button, x negative
		'{8'h80, 1'b0, '0},
		'{8'h01, 1'b1, '{3'd1, -128, -1, 0, 183}},   // clamp at zero x
		'{8'h2A, 1'b0, '0},  // right button, y negative
		'{8'h7F, 1'b0, '0},
		'{8'h80, 1'b1, '{3'd2, 127, 128, 127, 184}},
		'{8'h0C, 1'b0, '0},  // middle button; acknowledge value as X and Y data
		'{8'hFA, 1'b0, '0},
		'{8'hFA, 1'b0, '0}
	};

	initial begin
		forever #10 clk = ~clk;
	end

	// Clamp a signed sum into 0..lim
	function automatic logic [POS_W-1:0] clamp_cursor(input int sum, input logic [POS_W-1:0] lim);
		if (sum < 0)
			return '0;
		if (sum > int'(lim))
			return lim;
		return POS_W'(sum);
	endfunction

	// Advance the mirror by one accepted byte; done is set when a packet completes
	function automatic void decode_byte(input logic [7:0] b, output bit done, output move_t mv);
		int dx;
		int dy;
		done = 1'b0;
		mv = '0;
		case (frame_phase)
			PH_ACK: begin
				if (b == ACK_BYTE)
					frame_phase = PH_HDR;
			end
			PH_HDR: begin
				if ((b & HDR_CHECK_MASK) == HDR_CHECK_VALUE) begin
					hdr_seen = b;
					frame_phase = PH_X;
				end
			end
			PH_X: begin
				x_seen = b;
				frame_phase = PH_Y;
			end
			default: begin
				frame_phase = PH_HDR;
				dx = int'(x_seen) - (hdr_seen[X_SIGN_POS] ? 256 : 0);
				dy = -(int'(b) - (hdr_seen[Y_SIGN_POS] ? 256 : 0));
				pos_x = clamp_cursor(int'(pos_x) + dx, lim_x);
				pos_y = clamp_cursor(int'(pos_y) + dy, lim_y);
				mv.buttons = hdr_seen[2:0];
				mv.dx = 9'(dx);
				mv.dy = 10'(dy);
				mv.cx = pos_x;
				mv.cy = pos_y;
				done = 1'b1;
			end
		endcase
	endfunction

	// Offer one byte, hold it until taken, then record what it should produce.
	// Idle gaps land before the beat so they fall on every framing phase.
	task automatic send_byte(input logic [7:0] b, input bit known, input move_t want);
		bit    done;
		move_t mv;
		while (!steady && $urandom_range(99) < 29) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mouse_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		decode_byte(b, done, mv);
		if (done)
			pending_moves.push_back(known ? want : mv);
	endtask

	// Drop push, drain every expected result, then let in-flight bytes settle
	task automatic drain_results();
		push <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both limits on back-to-back edges; the block is idle here
	task automatic write_limits(input logic [POS_W-1:0] mx, input logic [POS_W-1:0] my);
		cfg_we <= 1'b1;
		cfg_index <= REG_CURSOR_MAX_X;
		cfg_data <= mx;
		@(posedge clk);
		cfg_index <= REG_CURSOR_MAX_Y;
		cfg_data <= my;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_x = mx;
		lim_y = my;
	endtask

	// Mostly well-formed packets with random content; the rest raw noise bytes,
	// which may or may not land as headers depending on framing phase
	task automatic run_random_phase(input int count);
		int         sent;
		logic [7:0] hdr;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 80) begin
				hdr = (8'($urandom_range(255)) & ~HDR_CHECK_MASK) | HDR_CHECK_VALUE;
				send_byte(hdr, 1'b0, '0);
				send_byte(8'($urandom_range(255)), 1'b0, '0);
				send_byte(8'($urandom_range(255)), 1'b0, '0);
				sent += 3;
			end else begin
				send_byte(8'($urandom_range(255)), 1'b0, '0);
				sent += 1;
			end
		end
	endtask

	// Result side: compare each popped beat with the oldest expectation,
	// then choose whether to pop on the next edge.
	always @(posedge clk) begin
		move_t want;
		if (arst_n && pop && !empty) begin
			if (pending_moves.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: buttons=%0d dx=%0d dy=%0d x=%0d y=%0d",
						$time, buttons, delta_x, delta_y, cursor_x, cursor_y);
			end else begin
				want = pending_moves.pop_front();
				if (buttons !== want.buttons || delta_x !== want.dx || delta_y !== want.dy ||
					cursor_x !== want.cx || cursor_y !== want.cy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: expected b=%0d dx=%0d dy=%0d x=%0d y=%0d, got b=%0d dx=%0d dy=%0d x=%0d y=%0d",
							$time, want.buttons, want.dx, want.dy, want.cx, want.cy,
							buttons, delta_x, delta_y, cursor_x, cursor_y);
				end
			end
		end
		pop <= steady || ($urandom_range(99) >= 29);
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ps2_mouse_packet_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset limits
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(SCRIPT[i].mbyte, SCRIPT[i].known, SCRIPT[i].want);
		drain_results();

		// Widest limits
		write_limits('1, '1);
		run_random_phase(PHASE_ITEMS);
		drain_results();

		// Lower the limits under the current cursor
		write_limits(pos_x >> 1, pos_y >> 1);
		run_random_phase(PHASE_ITEMS);
		drain_results();

		// Zero limits: cursor pinned at the origin
		write_limits('0, '0);
		run_random_phase(PHASE_ITEMS);
		drain_results();

		// Random limits with no idling on either side
		write_limits(POS_W'($urandom_range(1023)), POS_W'($urandom_range(1023)));
		steady = 1'b1;
		run_random_phase(PHASE_ITEMS);
		drain_results();
		steady = 1'b0;

		// Back to the reset limits
		write_limits(MAX_X_RESET, MAX_Y_RESET);
		run_random_phase(PHASE_ITEMS);
		drain_results();

		if (mismatches == 0)
			$display("ps2_mouse_packet_decoder regression: pass");
		else
			$display("ps2_mouse_packet_decoder regression: fail");
		$finish;
	end

endmodule
